@@ rtl/core/bdc_pkg.sv @@
// Shared constants, types and the 2^(k/16) table for the box delta decoder.
package bdc_pkg;

    // Register stages from input to the result register.
    localparam int PIPE_DEPTH = 7;

    // Configuration register indexes.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd1000;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd600;

    // log2(e) in Q.16, and the bias that makes the Q.28 exponent positive.
    localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;
    localparam logic signed [33:0] EXP_BIAS  = 34'sd4294967296;

    // Exponent code at which the scale shift is zero (16 + 5).
    localparam logic [4:0] SHIFT_ZERO_CODE = 5'd21;

    typedef struct packed {
        logic [15:0] score;
        logic [8:0]  roi_tag;
        logic [4:0]  class_tag;
    } side_t;

    // 2^(k/16) in Q.16, k = 0..15
    function automatic logic [16:0] pow2_frac(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd68438;
            5'd2:    v = 17'd71468;
            5'd3:    v = 17'd74632;
            5'd4:    v = 17'd77936;
            5'd5:    v = 17'd81386;
            5'd6:    v = 17'd84990;
            5'd7:    v = 17'd88752;
            5'd8:    v = 17'd92682;
            5'd9:    v = 17'd96785;
            5'd10:   v = 17'd101070;
            5'd11:   v = 17'd105545;
            5'd12:   v = 17'd110218;
            5'd13:   v = 17'd115098;
            5'd14:   v = 17'd120194;
            5'd15:   v = 17'd125515;
            default: v = 17'd0;  // 131072 does not fit; handled by caller
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/box_delta_decode_clip.sv @@
// Top level of the box delta decoder with clamp to the image.
//
// Input channel (in_valid / in_stall): one request per cycle unless stalled,
// a proposal box in unsigned Q12.4 with four signed Q4.12 deltas, a score and
// two tags. Output channel (out_valid / out_stall): the decoded box corners
// clamped to [0, image size - 1], with score and tags copied alongside.
// Config channel (cfg_valid / cfg_ready): cfg_index 0 writes image_width,
// 1 writes image_height. Always ready; write only while the pipe is empty.
// Throughput is one request per cycle unless the output stalls, set by
// a 7-stage pipe per axis (size and products, table interpolation, scale
// multiply, shift, add, clamp).
// A stall on a valid result freezes every stage at once and raises in_stall in
// the same cycle, so nothing is dropped or duplicated.
// Reset empties the pipe and loads image size 1000 x 600.
module box_delta_decode_clip (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        box_xmin,
    input  logic [15:0]        box_ymin,
    input  logic [15:0]        box_xmax,
    input  logic [15:0]        box_ymax,
    input  logic signed [15:0] delta_x,
    input  logic signed [15:0] delta_y,
    input  logic signed [15:0] delta_w,
    input  logic signed [15:0] delta_h,
    input  logic [15:0]        class_score,
    input  logic [8:0]         roi_tag,
    input  logic [4:0]         class_tag,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        out_x1,
    output logic [15:0]        out_y1,
    output logic [15:0]        out_x2,
    output logic [15:0]        out_y2,
    output logic [15:0]        out_score,
    output logic [8:0]         out_roi_tag,
    output logic [4:0]         out_class_tag,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_data
);

    logic [bdc_pkg::PIPE_DEPTH-1:0] valid_reg;
    bdc_pkg::side_t                 side_reg [bdc_pkg::PIPE_DEPTH];
    logic [12:0]                    img_w_reg, img_h_reg;
    logic                           en;

    // whole pipe moves unless the result register is held
    assign en        = !(valid_reg[bdc_pkg::PIPE_DEPTH-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = valid_reg[bdc_pkg::PIPE_DEPTH-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            img_w_reg <= bdc_pkg::IMAGE_WIDTH_RST;
            img_h_reg <= bdc_pkg::IMAGE_HEIGHT_RST;
        end
        else
        begin
            if (en)
                valid_reg <= {valid_reg[bdc_pkg::PIPE_DEPTH-2:0], in_valid};
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bdc_pkg::REG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
                    bdc_pkg::REG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // pass-through fields ride a shift line beside the datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{score: class_score, roi_tag: roi_tag, class_tag: class_tag};
            for (int i = 1; i < bdc_pkg::PIPE_DEPTH; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    bdc_axis u_axis_x (
        .clk   (clk),
        .en    (en),
        .mn    (box_xmin),
        .mx    (box_xmax),
        .dc    (delta_x),
        .ds    (delta_w),
        .limit (img_w_reg),
        .lo    (out_x1),
        .hi    (out_x2)
    );

    bdc_axis u_axis_y (
        .clk   (clk),
        .en    (en),
        .mn    (box_ymin),
        .mx    (box_ymax),
        .dc    (delta_y),
        .ds    (delta_h),
        .limit (img_h_reg),
        .lo    (out_y1),
        .hi    (out_y2)
    );

    assign out_score     = side_reg[bdc_pkg::PIPE_DEPTH-1].score;
    assign out_roi_tag   = side_reg[bdc_pkg::PIPE_DEPTH-1].roi_tag;
    assign out_class_tag = side_reg[bdc_pkg::PIPE_DEPTH-1].class_tag;

endmodule

@@ rtl/core/bdc_axis.sv @@
// One axis of the box decoder: size, center shift, exp scale and clamp, 7 stages.
module bdc_axis (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        mn,
    input  logic [15:0]        mx,
    input  logic signed [15:0] dc,
    input  logic signed [15:0] ds,
    input  logic [12:0]        limit,
    output logic [15:0]        lo,
    output logic [15:0]        hi
);

    // stage 1
    logic signed [17:0] s1_size_reg, s1_size_next;
    logic [17:0]        s1_sum_reg, s1_sum_next;
    logic signed [15:0] s1_dc_reg;
    logic signed [33:0] s1_t_reg, s1_t_next;
    // stage 2
    logic signed [35:0] s2_pc_reg, s2_pc_next;
    logic [36:0]        s2_dprod_reg, s2_dprod_next;
    logic [16:0]        s2_lo_reg, s2_lo_next;
    logic [4:0]         s2_code_reg;
    logic [16:0]        s2_mag_reg, s2_mag_next;
    logic               s2_neg_reg;
    // stage 3
    logic signed [35:0] s3_pc_reg;
    logic [17:0]        s3_m_reg, s3_m_next;
    logic [4:0]         s3_code_reg;
    logic [16:0]        s3_mag_reg;
    logic               s3_neg_reg;
    // stage 4
    logic signed [35:0] s4_pc_reg;
    logic [34:0]        s4_prod_reg, s4_prod_next;
    logic [4:0]         s4_code_reg;
    logic               s4_neg_reg;
    // stage 5
    logic signed [35:0] s5_pc_reg;
    logic [44:0]        s5_half_reg, s5_half_next;
    logic               s5_neg_reg;
    // stage 6
    logic signed [46:0] s6_vlo_reg, s6_vlo_next, s6_vhi_reg, s6_vhi_next;
    // stage 7
    logic [15:0]        s7_lo_reg, s7_lo_next, s7_hi_reg, s7_hi_next;

    logic [33:0]        u;
    logic [16:0]        tab_lo, tab_hi;
    logic [12:0]        diff;
    logic [17:0]        mag_full;
    logic [4:0]         sh;
    logic [34:0]        rs_tmp;
    logic [44:0]        rs_sum;
    logic signed [45:0] half_s;
    logic signed [13:0] lim_m1;
    logic signed [46:0] bound;

    always_comb
    begin
        s1_size_next = $signed({2'b00, mx}) - $signed({2'b00, mn}) + 18'sd16;
        s1_sum_next  = {2'b00, mx} + {2'b00, mn} + 18'd16;
        s1_t_next    = 34'(ds * bdc_pkg::LOG2E_Q16);
    end

    // stage 2: center shift product, table lookup and interpolation product
    always_comb
    begin
        s2_pc_next = $signed({7'b0, s1_sum_reg, 11'b0}) + 36'(s1_size_reg * s1_dc_reg);
        u          = unsigned'(s1_t_reg + bdc_pkg::EXP_BIAS);
        tab_lo     = bdc_pkg::pow2_frac({1'b0, u[27:24]});
        // top entry is 2^17, one past the 17-bit range
        tab_hi     = (u[27:24] == 4'hF) ? 17'd0 : bdc_pkg::pow2_frac({1'b0, u[27:24]} + 5'd1);
        diff       = (u[27:24] == 4'hF) ? 13'(18'd131072 - {1'b0, tab_lo})
                                        : 13'(tab_hi - tab_lo);
        s2_dprod_next = 37'(diff * u[23:0]);
        s2_lo_next    = tab_lo;
        mag_full      = s1_size_reg[17] ? 18'(-s1_size_reg) : unsigned'(s1_size_reg);
        s2_mag_next   = mag_full[16:0];
    end

    assign s3_m_next    = {1'b0, s2_lo_reg} + {5'b0, s2_dprod_reg[36:24]};
    assign s4_prod_next = 35'(s3_mag_reg * s3_m_reg);

    // stage 5: scale by 2^(ip-5), round half up on right shifts
    always_comb
    begin
        sh     = bdc_pkg::SHIFT_ZERO_CODE - s4_code_reg;
        rs_tmp = s4_prod_reg >> (sh - 5'd1);
        rs_sum = {10'b0, rs_tmp} + 45'd1;
        if (s4_code_reg >= bdc_pkg::SHIFT_ZERO_CODE)
            s5_half_next = {10'b0, s4_prod_reg} << (s4_code_reg - bdc_pkg::SHIFT_ZERO_CODE);
        else
            s5_half_next = rs_sum >> 1;
    end

    always_comb
    begin
        half_s      = s5_neg_reg ? -$signed({1'b0, s5_half_reg}) : $signed({1'b0, s5_half_reg});
        s6_vlo_next = 47'(s5_pc_reg) - 47'(half_s);
        s6_vhi_next = 47'(s5_pc_reg) + 47'(half_s);
    end

    function automatic logic [15:0] clip(input logic signed [46:0] v,
                                         input logic signed [46:0] b);
        logic signed [46:0] r;
        logic [46:0]        rp;
        r  = (v < b) ? v : b;
        if (r < 0)
            r = '0;
        rp = unsigned'(r) + 47'd2048;
        return (|rp[46:28]) ? 16'hFFFF : rp[27:12];
    endfunction

    always_comb
    begin
        lim_m1     = $signed({1'b0, limit}) - 14'sd1;
        bound      = 47'($signed({lim_m1, 16'b0}));
        s7_lo_next = clip(s6_vlo_reg, bound);
        s7_hi_next = clip(s6_vhi_reg, bound);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_size_reg  <= s1_size_next;
            s1_sum_reg   <= s1_sum_next;
            s1_dc_reg    <= dc;
            s1_t_reg     <= s1_t_next;
            s2_pc_reg    <= s2_pc_next;
            s2_dprod_reg <= s2_dprod_next;
            s2_lo_reg    <= s2_lo_next;
            s2_code_reg  <= u[32:28];
            s2_mag_reg   <= s2_mag_next;
            s2_neg_reg   <= s1_size_reg[17];
            s3_pc_reg    <= s2_pc_reg;
            s3_m_reg     <= s3_m_next;
            s3_code_reg  <= s2_code_reg;
            s3_mag_reg   <= s2_mag_reg;
            s3_neg_reg   <= s2_neg_reg;
            s4_pc_reg    <= s3_pc_reg;
            s4_prod_reg  <= s4_prod_next;
            s4_code_reg  <= s3_code_reg;
            s4_neg_reg   <= s3_neg_reg;
            s5_pc_reg    <= s4_pc_reg;
            s5_half_reg  <= s5_half_next;
            s5_neg_reg   <= s4_neg_reg;
            s6_vlo_reg   <= s6_vlo_next;
            s6_vhi_reg   <= s6_vhi_next;
            s7_lo_reg    <= s7_lo_next;
            s7_hi_reg    <= s7_hi_next;
        end
    end

    assign lo = s7_lo_reg;
    assign hi = s7_hi_reg;

endmodule

@@ rtl/core/bdc_checker.sv @@
// Port-level checks for the box delta decoder, bound to the top level.
module bdc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [15:0]        out_x1,
    input logic [15:0]        out_y2,
    input logic [15:0]        out_score,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    // held result keeps its request
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x1) && $stable(out_y2)
                                   && $stable(out_score))
        else $error("held result changed");

    // input backpressure only comes from a blocked result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // result register drains when the receiver takes it
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> !in_stall)
        else $error("input stalled while result drains");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind box_delta_decode_clip bdc_checker u_bdc_checker (.*);
